// ===== rtl/core/mba_pkg.sv =====
// Shared types and constants for the mosaic block averager.
`timescale 1ns / 1ps
`default_nettype none

package mba_pkg;

    localparam int CH_W  = 8;
    localparam int SUM_W = 24;
    localparam int CNT_W = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_BLOCK  = 255;

    localparam logic [ADDR_W-1:0] ADDR_IMAGE_WIDTH  = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_IMAGE_HEIGHT = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_BLOCK_SIZE   = 4'h8;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] alpha;
    } sums_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } means_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/mba_accum.sv =====
// Column sum memory with read-modify-write accumulation of one pixel.
`timescale 1ns / 1ps
`default_nettype none

module mba_accum #(
    parameter int DEPTH = 2049,
    parameter int IDX_W = 12
) (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic [IDX_W-1:0]          rd_addr,
    input  wire logic                      wr_en,
    input  wire logic [IDX_W-1:0]          wr_addr,
    input  wire logic                      first,
    input  wire logic [31:0]               pixel,
    output mba_pkg::sums_t                 new_sums
);
    import mba_pkg::*;

    sums_t mem [DEPTH];
    sums_t rd_data_reg;
    sums_t base;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= new_sums;
        end
    end

    always_comb
    begin
        if (first)
        begin
            base = '0;
        end
        else
        begin
            base = rd_data_reg;
        end
        new_sums.red   = base.red   + SUM_W'(pixel[7:0]);
        new_sums.green = base.green + SUM_W'(pixel[15:8]);
        new_sums.blue  = base.blue  + SUM_W'(pixel[23:16]);
        new_sums.alpha = base.alpha + SUM_W'(pixel[31:24]);
    end

endmodule

`default_nettype wire

// ===== rtl/core/mba_divider.sv =====
// Four-lane restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mba_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  mba_pkg::div_ctrl_t ctrl,
    input  mba_pkg::sums_t   sums,
    output logic             done,
    output mba_pkg::means_t  means
);
    import mba_pkg::*;

    sums_t            rem_reg;
    means_t           quo_reg;
    logic [SUM_W-1:0] dvs_reg;
    logic [2:0]       step_reg;
    logic             busy_reg;

    assign means = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= sums;
            quo_reg <= '0;
            dvs_reg <= {1'b0, ctrl.count, 7'b0};
        end
        else if (busy_reg)
        begin
            dvs_reg <= dvs_reg >> 1;
            if (rem_reg.red >= dvs_reg)
            begin
                rem_reg.red <= rem_reg.red - dvs_reg;
            end
            if (rem_reg.green >= dvs_reg)
            begin
                rem_reg.green <= rem_reg.green - dvs_reg;
            end
            if (rem_reg.blue >= dvs_reg)
            begin
                rem_reg.blue <= rem_reg.blue - dvs_reg;
            end
            if (rem_reg.alpha >= dvs_reg)
            begin
                rem_reg.alpha <= rem_reg.alpha - dvs_reg;
            end
            quo_reg.red   <= {quo_reg.red[6:0],   rem_reg.red   >= dvs_reg};
            quo_reg.green <= {quo_reg.green[6:0], rem_reg.green >= dvs_reg};
            quo_reg.blue  <= {quo_reg.blue[6:0],  rem_reg.blue  >= dvs_reg};
            quo_reg.alpha <= {quo_reg.alpha[6:0], rem_reg.alpha >= dvs_reg};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mosaic_block_average.sv =====
// Top level of the mosaic block averager: registers, raster control and result register.
//
//  channel | signals                                   | direction
//  pixel   | in_valid, in_ready, pixel                 | in
//  block   | out_valid, out_ready, block_* / mean_*    | out
//  config  | psel, penable, pwrite, paddr, pwdata ...  | in
//
// An item that ends no block passes only through the read-modify-write of the column sum memory;
// one that ends a block then also runs through the eight-step divider.
// A finished result waits in the output register while the next item is taken.
// Reset clears the registers and positions; the sum memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module mosaic_block_average #(
    parameter int MAX_WIDTH  = mba_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mba_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = mba_pkg::DEF_MAX_BLOCK
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mba_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mba_pkg::DATA_W-1:0]  pwdata,
    output logic      [mba_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [31:0]                 pixel,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [10:0]                      block_column,
    output logic [10:0]                      block_row,
    output logic [7:0]                       block_width,
    output logic [7:0]                       block_height,
    output logic [7:0]                       mean_red,
    output logic [7:0]                       mean_green,
    output logic [7:0]                       mean_blue,
    output logic [7:0]                       mean_alpha,
    output logic                             last_block
);
    import mba_pkg::*;

    localparam int DEPTH  = MAX_WIDTH / 2 + 1;
    localparam int COL_W  = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT / 2 + 1);
    localparam int XPOS_W = $clog2(MAX_WIDTH + 1);
    localparam int YPOS_W = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {S_IDLE, S_RMW, S_START, S_DIV, S_HOLD} state_t;

    state_t state_reg;

    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [7:0]  block_size_reg;

    logic [XPOS_W-1:0] xpos_reg;
    logic [YPOS_W-1:0] ypos_reg;
    logic [7:0]        phase_x_reg;
    logic [7:0]        phase_y_reg;
    logic [COL_W-1:0]  bcol_reg;
    logic [ROW_W-1:0]  brow_reg;

    logic [31:0]       pix_reg;
    logic              first_reg;
    logic              emit_reg;
    logic              last_reg;
    logic [COL_W-1:0]  cap_col_reg;
    logic [ROW_W-1:0]  cap_row_reg;
    logic [7:0]        bw_reg;
    logic [7:0]        bh_reg;
    logic [CNT_W-1:0]  cnt_reg;
    sums_t             sums_reg;

    logic [XPOS_W-1:0] w_eff;
    logic [YPOS_W-1:0] h_eff;
    logic [7:0]        b_eff;
    logic              enabled;
    logic              restart;
    logic [XPOS_W-1:0] xp;
    logic [YPOS_W-1:0] yp;
    logic [7:0]        px;
    logic [7:0]        py;
    logic [COL_W-1:0]  bc;
    logic [ROW_W-1:0]  br;
    logic              row_end;
    logic              col_end;
    logic              px_last;
    logic              py_last;
    logic              in_acc;
    logic              cfg_wr;
    logic              load_out;

    sums_t     new_sums;
    div_ctrl_t div_ctrl;
    logic      div_done;
    means_t    means;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign load_out = (state_reg == S_HOLD) && (!out_valid || out_ready);

    always_comb
    begin
        w_eff = (32'(image_width_reg) > 32'(MAX_WIDTH)) ? XPOS_W'(MAX_WIDTH)
                                                         : XPOS_W'(image_width_reg);
        h_eff = (32'(image_height_reg) > 32'(MAX_HEIGHT)) ? YPOS_W'(MAX_HEIGHT)
                                                           : YPOS_W'(image_height_reg);
        b_eff = (32'(block_size_reg) > 32'(MAX_BLOCK)) ? 8'(MAX_BLOCK) : block_size_reg;
        enabled = (w_eff != '0) && (h_eff != '0) && (b_eff > 8'd1);
        restart = (xpos_reg >= w_eff) || (ypos_reg >= h_eff);
        xp = restart ? '0 : xpos_reg;
        yp = restart ? '0 : ypos_reg;
        px = restart ? '0 : phase_x_reg;
        py = restart ? '0 : phase_y_reg;
        bc = restart ? '0 : bcol_reg;
        br = restart ? '0 : brow_reg;
        row_end = ({1'b0, xp} + 1'b1) == {1'b0, w_eff};
        col_end = ({1'b0, yp} + 1'b1) == {1'b0, h_eff};
        px_last = ({1'b0, px} + 9'd1) == {1'b0, b_eff};
        py_last = ({1'b0, py} + 9'd1) == {1'b0, b_eff};
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_IMAGE_WIDTH:  prdata = DATA_W'(image_width_reg);
            ADDR_IMAGE_HEIGHT: prdata = DATA_W'(image_height_reg);
            ADDR_BLOCK_SIZE:   prdata = DATA_W'(block_size_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
            block_size_reg   <= '0;
            xpos_reg         <= '0;
            ypos_reg         <= '0;
            phase_x_reg      <= '0;
            phase_y_reg      <= '0;
            bcol_reg         <= '0;
            brow_reg         <= '0;
        end
        else if (cfg_wr && (paddr == ADDR_IMAGE_WIDTH || paddr == ADDR_IMAGE_HEIGHT
                            || paddr == ADDR_BLOCK_SIZE))
        begin
            if (paddr == ADDR_IMAGE_WIDTH)
            begin
                image_width_reg <= pwdata[12:0];
            end
            if (paddr == ADDR_IMAGE_HEIGHT)
            begin
                image_height_reg <= pwdata[12:0];
            end
            if (paddr == ADDR_BLOCK_SIZE)
            begin
                block_size_reg <= pwdata[7:0];
            end
            xpos_reg    <= '0;
            ypos_reg    <= '0;
            phase_x_reg <= '0;
            phase_y_reg <= '0;
            bcol_reg    <= '0;
            brow_reg    <= '0;
        end
        else if (in_acc && enabled)
        begin
            if (row_end)
            begin
                xpos_reg    <= '0;
                phase_x_reg <= '0;
                bcol_reg    <= '0;
                if (col_end)
                begin
                    ypos_reg    <= '0;
                    phase_y_reg <= '0;
                    brow_reg    <= '0;
                end
                else
                begin
                    ypos_reg <= yp + 1'b1;
                    if (py_last)
                    begin
                        phase_y_reg <= '0;
                        brow_reg    <= br + 1'b1;
                    end
                    else
                    begin
                        phase_y_reg <= py + 8'd1;
                        brow_reg    <= br;
                    end
                end
            end
            else
            begin
                xpos_reg    <= xp + 1'b1;
                ypos_reg    <= yp;
                phase_y_reg <= py;
                brow_reg    <= br;
                if (px_last)
                begin
                    phase_x_reg <= '0;
                    bcol_reg    <= bc + 1'b1;
                end
                else
                begin
                    phase_x_reg <= px + 8'd1;
                    bcol_reg    <= bc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix_reg     <= pixel;
            first_reg   <= (px == 8'd0) && (py == 8'd0);
            emit_reg    <= (row_end || px_last) && (col_end || py_last);
            last_reg    <= row_end && col_end;
            cap_col_reg <= bc;
            cap_row_reg <= br;
            bw_reg      <= px + 8'd1;
            bh_reg      <= py + 8'd1;
        end
        if (state_reg == S_RMW)
        begin
            sums_reg <= new_sums;
            cnt_reg  <= bw_reg * bh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_valid    <= 1'b0;
            block_column <= '0;
            block_row    <= '0;
            block_width  <= '0;
            block_height <= '0;
            mean_red     <= '0;
            mean_green   <= '0;
            mean_blue    <= '0;
            mean_alpha   <= '0;
            last_block   <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && !load_out)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && enabled)
                    begin
                        state_reg <= S_RMW;
                    end
                end
                S_RMW:
                begin
                    state_reg <= emit_reg ? S_START : S_IDLE;
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (load_out)
                    begin
                        out_valid    <= 1'b1;
                        block_column <= 11'(cap_col_reg);
                        block_row    <= 11'(cap_row_reg);
                        block_width  <= bw_reg;
                        block_height <= bh_reg;
                        mean_red     <= means.red;
                        mean_green   <= means.green;
                        mean_blue    <= means.blue;
                        mean_alpha   <= means.alpha;
                        last_block   <= last_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign div_ctrl.start = (state_reg == S_START);
    assign div_ctrl.count = cnt_reg;

    mba_accum #(
        .DEPTH (DEPTH),
        .IDX_W (COL_W)
    ) u_accum (
        .clk      (clk),
        .rd_en    (in_acc),
        .rd_addr  (bc),
        .wr_en    (state_reg == S_RMW),
        .wr_addr  (cap_col_reg),
        .first    (first_reg),
        .pixel    (pix_reg),
        .new_sums (new_sums)
    );

    mba_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .sums  (sums_reg),
        .done  (div_done),
        .means (means)
    );

endmodule

`default_nettype wire

// ===== test/mosaic_block_average_test.sv =====
// Self-checking testbench for the mosaic block averager with a scoreboard class.
`timescale 1ns / 1ps

module mosaic_block_average_test;

    import mba_pkg::*;

    typedef struct {
        logic [10:0] col;
        logic [10:0] row;
        logic [7:0]  bw;
        logic [7:0]  bh;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        last;
    } block_mean_t;

    class mosaic_scoreboard;
        int unsigned cfg_w, cfg_h, cfg_b;
        logic [23:0] sum_r[2049];
        logic [23:0] sum_g[2049];
        logic [23:0] sum_b[2049];
        logic [23:0] sum_a[2049];
        int unsigned xpos, ypos, ph_x, ph_y, bcol, brow;
        block_mean_t pending[$];
        int errors;

        function void restart();
            xpos = 0; ypos = 0; ph_x = 0; ph_y = 0; bcol = 0; brow = 0;
        endfunction

        function void set_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
            if (addr == ADDR_IMAGE_WIDTH)
                cfg_w = value[12:0];
            else if (addr == ADDR_IMAGE_HEIGHT)
                cfg_h = value[12:0];
            else if (addr == ADDR_BLOCK_SIZE)
                cfg_b = value[7:0];
            else
                return;
            restart();
        endfunction

        function void note_pixel(logic [31:0] px);
            int unsigned w, h, bs, idx, cnt;
            bit row_end, col_end;
            block_mean_t e;
            w = (cfg_w > 4096) ? 4096 : cfg_w;
            h = (cfg_h > 4096) ? 4096 : cfg_h;
            bs = (cfg_b > 255) ? 255 : cfg_b;
            if (w == 0 || h == 0 || bs <= 1)
                return;
            if (xpos >= w || ypos >= h)
                restart();
            idx = (bcol > 2048) ? 2048 : bcol;
            if (ph_x == 0 && ph_y == 0)
            begin
                sum_r[idx] = 24'(px[7:0]); sum_g[idx] = 24'(px[15:8]);
                sum_b[idx] = 24'(px[23:16]); sum_a[idx] = 24'(px[31:24]);
            end
            else
            begin
                sum_r[idx] += 24'(px[7:0]); sum_g[idx] += 24'(px[15:8]);
                sum_b[idx] += 24'(px[23:16]); sum_a[idx] += 24'(px[31:24]);
            end
            row_end = (xpos + 1 == w);
            col_end = (ypos + 1 == h);
            if ((row_end || ph_x + 1 == bs) && (col_end || ph_y + 1 == bs))
            begin
                cnt = (ph_x + 1) * (ph_y + 1);
                e.col = 11'(bcol); e.row = 11'(brow);
                e.bw = 8'(ph_x + 1); e.bh = 8'(ph_y + 1);
                e.r = 8'(sum_r[idx] / cnt); e.g = 8'(sum_g[idx] / cnt);
                e.b = 8'(sum_b[idx] / cnt); e.a = 8'(sum_a[idx] / cnt);
                e.last = row_end && col_end;
                pending.push_back(e);
            end
            if (row_end)
            begin
                xpos = 0; ph_x = 0; bcol = 0;
                if (col_end)
                begin
                    ypos = 0; ph_y = 0; brow = 0;
                end
                else
                begin
                    ypos++;
                    if (ph_y + 1 == bs)
                    begin
                        ph_y = 0; brow++;
                    end
                    else
                        ph_y++;
                end
            end
            else
            begin
                xpos++;
                if (ph_x + 1 == bs)
                begin
                    ph_x = 0; bcol++;
                end
                else
                    ph_x++;
            end
        endfunction

        function void check_block(block_mean_t got);
            block_mean_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected block result at column %0d row %0d", got.col, got.row);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.col !== e.col) begin $error("block_column exp %0d got %0d", e.col, got.col); errors++; end
            if (got.row !== e.row) begin $error("block_row exp %0d got %0d", e.row, got.row); errors++; end
            if (got.bw !== e.bw) begin $error("block_width exp %0d got %0d", e.bw, got.bw); errors++; end
            if (got.bh !== e.bh) begin $error("block_height exp %0d got %0d", e.bh, got.bh); errors++; end
            if (got.r !== e.r) begin $error("mean_red exp %0d got %0d", e.r, got.r); errors++; end
            if (got.g !== e.g) begin $error("mean_green exp %0d got %0d", e.g, got.g); errors++; end
            if (got.b !== e.b) begin $error("mean_blue exp %0d got %0d", e.b, got.b); errors++; end
            if (got.a !== e.a) begin $error("mean_alpha exp %0d got %0d", e.a, got.a); errors++; end
            if (got.last !== e.last) begin $error("last_block exp %0d got %0d", e.last, got.last); errors++; end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] pixel = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [10:0] block_column, block_row;
    logic [7:0] block_width, block_height, mean_red, mean_green, mean_blue, mean_alpha;
    logic last_block;

    mosaic_block_average u_dut (.*);

    always #5 clk = ~clk;

    mosaic_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int unsigned hold_cycles = 0;
    bit recv_done = 1'b0;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off when requested.
    initial
    begin
        int gap;
        block_mean_t got;
        @(posedge rst_n);
        while (!recv_done)
        begin
            if (hold_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            got.col = block_column; got.row = block_row;
            got.bw = block_width; got.bh = block_height;
            got.r = mean_red; got.g = mean_green; got.b = mean_blue; got.a = mean_alpha;
            got.last = last_block;
            sb.check_block(got);
        end
    end

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(addr, value);
    endtask

    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned bs);
        wait_idle();
        write_reg(ADDR_IMAGE_WIDTH, w);
        write_reg(ADDR_IMAGE_HEIGHT, h);
        write_reg(ADDR_BLOCK_SIZE, bs);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_pixel(logic [31:0] px, bit busy);
        int gap;
        gap = busy ? 0 : $urandom_range(0, 16);
        if (!busy && $urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(px);
    endtask

    task automatic send_frame(int unsigned n, bit busy);
        repeat (n) send_pixel($urandom(), busy);
    endtask

    initial
    begin
        int unsigned w, h, bs;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled settings: pixels must be ignored.
        send_pixel(32'hFFFF_FFFF, 1'b0);
        configure(4, 4, 1);
        send_pixel(32'h0000_0000, 1'b0);
        configure(0, 4, 2);
        send_pixel(32'h1234_5678, 1'b0);
        configure(4, 0, 2);
        send_pixel(32'h1234_5678, 1'b0);

        // Extreme pixel values, even block tiling.
        configure(4, 2, 2);
        repeat (4) send_pixel(32'hFFFF_FFFF, 1'b0);
        repeat (4) send_pixel(32'h0000_0000, 1'b0);
        // Edge blocks cut short, then a frame wrap.
        configure(5, 3, 2);
        send_frame(15, 1'b0);
        send_frame(6, 1'b0);

        // Oversized block, registers above their maxima.
        configure(3, 2, 255);
        send_frame(6, 1'b0);
        configure(8191, 1, 2);
        send_frame(20, 1'b0);
        configure(4, 8191, 3);
        send_frame(24, 1'b0);

        // Mid-frame register write restarts the frame.
        configure(6, 6, 3);
        send_frame(10, 1'b0);
        configure(6, 6, 3);
        send_frame(36, 1'b0);

        // Long receiver hold-off while the sender keeps going.
        configure(4, 4, 2);
        hold_cycles = 300;
        send_frame(64, 1'b1);

        // Image at the maximum width, cut off within its first row, then a small frame.
        configure(4096, 2, 2);
        send_frame(200, 1'b0);
        configure(2, 2, 2);
        send_frame(4, 1'b0);

        // Random frames with small sizes.
        repeat (12)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            bs = $urandom_range(0, 7);
            if ($urandom_range(0, 9) == 0) bs = 255;
            configure(w, h, bs);
            send_frame(w * h * $urandom_range(1, 2) - $urandom_range(0, 1), 1'b0);
        end

        wait_idle();
        recv_done = 1'b1;
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
        begin
            if (sb.pending.size() != 0)
                $error("%0d block results never arrived", sb.pending.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
